// ===== rtl/core/load_store_multiple_sequencer_defines.svh =====
// Assertion macros for the load/store multiple sequencer checker.
// Included by the checker file; needs nothing else.
`ifndef LOAD_STORE_MULTIPLE_SEQUENCER_DEFINES_SVH
`define LOAD_STORE_MULTIPLE_SEQUENCER_DEFINES_SVH

// Implication that must hold in the same cycle.
`define LSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define LSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lsm_pkg.sv =====
// Shared constants, types and helper functions for the load/store multiple sequencer.
// No dependencies; used by every module of the block.
package lsm_pkg;

    localparam int unsigned LIST_W     = 16;
    localparam int unsigned REG_W      = 4;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned IN_TDATA_W = 96;
    localparam int unsigned TDATA_W    = 104;
    localparam int unsigned TUSER_W    = 2;

    // Instruction flag bit positions.
    localparam int unsigned BIT_LOAD  = 20;
    localparam int unsigned BIT_WBACK = 21;
    localparam int unsigned BIT_USER  = 22;
    localparam int unsigned BIT_UP    = 23;
    localparam int unsigned BIT_PRE   = 24;

    localparam logic [WORD_W-1:0]  WORD_BYTES      = 32'd4;
    localparam logic [WORD_W-1:0]  PC_STORE_OFFSET = 32'd12;
    localparam logic [REG_W-1:0]   PC_REG          = 4'd15;

    // Result of the lowest-set-bit search over the remaining register list.
    typedef struct packed {
        logic [REG_W-1:0]  idx;
        logic [LIST_W-1:0] rest;
        logic              is_last;
    } pick_t;

    function automatic logic [COUNT_W-1:0] count_bits(input logic [LIST_W-1:0] list);
        logic [COUNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < LIST_W; i++)
        begin
            n = n + COUNT_W'(list[i]);
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/lsm_addsub.sv =====
// Shared 32-bit adder/subtractor used for every address sum of the sequencer.
// Depends on lsm_pkg for the word width.
module lsm_addsub (
    input  logic [lsm_pkg::WORD_W-1:0] a,
    input  logic [lsm_pkg::WORD_W-1:0] b,
    input  logic                       sub,
    output logic [lsm_pkg::WORD_W-1:0] y
);

    // Two's complement subtraction folded into the one carry chain.
    assign y = a + (sub ? ~b : b) + lsm_pkg::WORD_W'(sub);

endmodule

// ===== rtl/core/lsm_pick.sv =====
// Lowest-set-bit picker over the remaining register list.
// Depends on lsm_pkg for the pick_t result type.
module lsm_pick (
    input  logic [lsm_pkg::LIST_W-1:0] list,
    output lsm_pkg::pick_t             pick
);

    logic [lsm_pkg::LIST_W-1:0] list_dec;
    logic [lsm_pkg::LIST_W-1:0] low_bit;
    logic [lsm_pkg::REG_W-1:0]  idx;

    assign list_dec = list - lsm_pkg::LIST_W'(1);
    assign low_bit  = list & ~list_dec;

    // One-hot to binary encode of the lowest set bit.
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < lsm_pkg::LIST_W; i++)
        begin
            if (low_bit[i])
            begin
                idx = idx | lsm_pkg::REG_W'(i);
            end
        end
    end

    assign pick.idx     = idx;
    assign pick.rest    = list & list_dec;
    assign pick.is_last = (pick.rest == '0);

endmodule

// ===== rtl/core/load_store_multiple_sequencer.sv =====
// Load/store multiple address sequencer: top level with the control sequencer.
// Depends on lsm_pkg, lsm_addsub and lsm_pick.
//
// Usage: one block-transfer instruction arrives as a slave-side stream
// transaction carrying the instruction word, the base register value and the
// instruction address. The block then produces one master-side transaction
// per register named in the 16-bit list, lowest register first, each with its
// word address, register number, direction and, on the final transaction,
// the base write-back. tlast marks the final transaction of an instruction.
// A user-bank instruction gives a single illegal transaction, and an empty
// list gives a single non-transfer transaction carrying only the write-back.
// Sequence: after acceptance a single 32-bit adder forms in turn the
// write-back value, the start address and the stored PC value, then one
// transaction per cycle is given while the receiver is ready, the same
// adder stepping the address by four. s_axis_tready is high only while
// the block is idle. When the receiver stalls, the pending transaction
// holds its value until taken. Reset returns the sequencer to idle with
// no transaction pending.
module load_store_multiple_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata from bit 0: instruction[31:0], base_value[63:32], instr_address[95:64]
    input  logic [lsm_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata from bit 0: word_address[31:0], reg_index[35:32], is_load[36],
    // pc_store_value[68:37], pc_written[69], writeback_valid[70],
    // writeback_value[102:71], zero padding[103]
    output logic [lsm_pkg::TDATA_W-1:0]    m_axis_tdata,
    // tuser from bit 0: transfer_valid[0], illegal[1]
    output logic [lsm_pkg::TUSER_W-1:0]    m_axis_tuser,
    output logic                           m_axis_tlast
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WB     = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_PC     = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;
    localparam logic [2:0] ST_SINGLE = 3'd5;

    localparam int unsigned WW = lsm_pkg::WORD_W;

    logic [2:0]                  state_reg, state_next;
    logic [lsm_pkg::LIST_W-1:0]  list_reg, list_next;
    logic [lsm_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic [WW-1:0]               base_reg, base_next;
    logic [WW-1:0]               iaddr_reg, iaddr_next;
    logic [WW-1:0]               addr_reg, addr_next;
    logic [WW-1:0]               wbval_reg, wbval_next;
    logic [WW-1:0]               pcval_reg, pcval_next;
    logic                        load_reg, load_next;
    logic                        wback_reg, wback_next;
    logic                        up_reg, up_next;
    logic                        pre_reg, pre_next;
    logic                        ill_reg, ill_next;

    logic [WW-1:0] in_insn;
    logic [WW-1:0] in_base;
    logic [WW-1:0] in_iaddr;
    logic          in_fire;
    logic          out_fire;

    logic [WW-1:0] add_a;
    logic [WW-1:0] add_b;
    logic          add_sub;
    logic [WW-1:0] add_y;

    lsm_pkg::pick_t pick;

    // Output field values.
    logic                       o_tv;
    logic [WW-1:0]              o_addr;
    logic [lsm_pkg::REG_W-1:0]  o_reg;
    logic                       o_load;
    logic [WW-1:0]              o_pcv;
    logic                       o_pcw;
    logic                       o_wbv;
    logic [WW-1:0]              o_wbval;
    logic                       o_ill;
    logic                       o_last;
    logic                       is_pc;

    assign in_insn  = s_axis_tdata[WW-1:0];
    assign in_base  = s_axis_tdata[2*WW-1:WW];
    assign in_iaddr = s_axis_tdata[3*WW-1:2*WW];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT) || (state_reg == ST_SINGLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    lsm_addsub u_addsub (
        .a   (add_a),
        .b   (add_b),
        .sub (add_sub),
        .y   (add_y)
    );

    lsm_pick u_pick (
        .list (list_reg),
        .pick (pick)
    );

    // Operand selection for the shared adder, one sum per sequencer step.
    always_comb
    begin
        add_a   = addr_reg;
        add_b   = lsm_pkg::WORD_BYTES;
        add_sub = 1'b0;
        unique case (state_reg)
            ST_WB:
            begin
                // Write-back value: base plus or minus four times the count.
                add_a   = base_reg;
                add_b   = {{(WW - lsm_pkg::COUNT_W - 2){1'b0}}, cnt_reg, 2'b00};
                add_sub = !up_reg;
            end
            ST_START:
            begin
                // Counting up starts from the base; counting down starts from
                // the lowest address, which is the write-back value.
                add_a = up_reg ? base_reg : wbval_reg;
                add_b = (up_reg == pre_reg) ? lsm_pkg::WORD_BYTES : '0;
            end
            ST_PC:
            begin
                add_a = iaddr_reg;
                add_b = lsm_pkg::PC_STORE_OFFSET;
            end
            default:
            begin
                add_a   = addr_reg;
                add_b   = lsm_pkg::WORD_BYTES;
                add_sub = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        list_next  = list_reg;
        cnt_next   = cnt_reg;
        base_next  = base_reg;
        iaddr_next = iaddr_reg;
        addr_next  = addr_reg;
        wbval_next = wbval_reg;
        pcval_next = pcval_reg;
        load_next  = load_reg;
        wback_next = wback_reg;
        up_next    = up_reg;
        pre_next   = pre_reg;
        ill_next   = ill_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    list_next  = in_insn[lsm_pkg::LIST_W-1:0];
                    cnt_next   = lsm_pkg::count_bits(in_insn[lsm_pkg::LIST_W-1:0]);
                    base_next  = in_base;
                    iaddr_next = in_iaddr;
                    load_next  = in_insn[lsm_pkg::BIT_LOAD];
                    wback_next = in_insn[lsm_pkg::BIT_WBACK];
                    ill_next   = in_insn[lsm_pkg::BIT_USER];
                    up_next    = in_insn[lsm_pkg::BIT_UP];
                    pre_next   = in_insn[lsm_pkg::BIT_PRE];
                    if (in_insn[lsm_pkg::BIT_USER] ||
                        (in_insn[lsm_pkg::LIST_W-1:0] == '0))
                    begin
                        state_next = ST_SINGLE;
                    end
                    else
                    begin
                        state_next = ST_WB;
                    end
                end
            end
            ST_WB:
            begin
                wbval_next = add_y;
                state_next = ST_START;
            end
            ST_START:
            begin
                addr_next  = add_y;
                state_next = ST_PC;
            end
            ST_PC:
            begin
                pcval_next = add_y;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    addr_next = add_y;
                    list_next = pick.rest;
                    if (pick.is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SINGLE:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers carry payload only and need no reset.
    always_ff @(posedge clk)
    begin
        list_reg  <= list_next;
        cnt_reg   <= cnt_next;
        base_reg  <= base_next;
        iaddr_reg <= iaddr_next;
        addr_reg  <= addr_next;
        wbval_reg <= wbval_next;
        pcval_reg <= pcval_next;
        load_reg  <= load_next;
        wback_reg <= wback_next;
        up_reg    <= up_next;
        pre_reg   <= pre_next;
        ill_reg   <= ill_next;
    end

    // Result fields. In the transfer phase they follow the lowest remaining
    // register; otherwise the single illegal or empty-list result is shown,
    // with every field that has no meaning forced to zero.
    assign is_pc = (pick.idx == lsm_pkg::PC_REG);

    always_comb
    begin
        if (state_reg == ST_EMIT)
        begin
            o_tv    = 1'b1;
            o_addr  = addr_reg;
            o_reg   = pick.idx;
            o_load  = load_reg;
            o_pcv   = (!load_reg && is_pc) ? pcval_reg : '0;
            o_pcw   = load_reg && is_pc;
            o_wbv   = pick.is_last && wback_reg;
            o_wbval = (pick.is_last && wback_reg) ? wbval_reg : '0;
            o_ill   = 1'b0;
            o_last  = pick.is_last;
        end
        else
        begin
            o_tv    = 1'b0;
            o_addr  = '0;
            o_reg   = '0;
            o_load  = 1'b0;
            o_pcv   = '0;
            o_pcw   = 1'b0;
            o_wbv   = !ill_reg && wback_reg;
            o_wbval = (!ill_reg && wback_reg) ? base_reg : '0;
            o_ill   = ill_reg;
            o_last  = 1'b1;
        end
    end

    assign m_axis_tdata = {1'b0, o_wbval, o_wbv, o_pcw, o_pcv, o_load, o_reg, o_addr};
    assign m_axis_tuser = {o_ill, o_tv};
    assign m_axis_tlast = o_last;

endmodule

// ===== rtl/core/lsm_checker.sv =====
// Port-level checker for the load/store multiple sequencer, bound to the top level.
// Depends on lsm_pkg and the assertion macros in load_store_multiple_sequencer_defines.svh.
`include "load_store_multiple_sequencer_defines.svh"

module lsm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [lsm_pkg::TDATA_W-1:0]    m_axis_tdata,
    input logic [lsm_pkg::TUSER_W-1:0]    m_axis_tuser,
    input logic                           m_axis_tlast
);

    localparam int unsigned BEAT_W = lsm_pkg::TDATA_W + lsm_pkg::TUSER_W + 1;

    logic                       in_take;
    logic                       out_stall;
    logic                       step_take;
    logic                       ill_shown;
    logic                       lone_end;
    logic [lsm_pkg::WORD_W-1:0] want_addr_next;
    logic [lsm_pkg::WORD_W-1:0] want_addr_reg;
    logic                       step_ok;
    logic [BEAT_W-1:0]          beat_next;
    logic [BEAT_W-1:0]          beat_reg;
    logic                       hold_ok;

    assign in_take        = s_axis_tvalid && s_axis_tready;
    assign out_stall      = m_axis_tvalid && !m_axis_tready;
    assign step_take      = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
    assign ill_shown      = m_axis_tvalid && m_axis_tuser[1];
    assign lone_end       = m_axis_tlast && !m_axis_tuser[0];
    assign want_addr_next = m_axis_tdata[lsm_pkg::WORD_W-1:0] + lsm_pkg::WORD_BYTES;
    assign beat_next      = {m_axis_tuser, m_axis_tlast, m_axis_tdata};

    // Previous-cycle copies of the address step and of the whole result.
    always_ff @(posedge clk)
    begin
        want_addr_reg <= want_addr_next;
        beat_reg      <= beat_next;
    end

    assign step_ok = m_axis_tvalid && (m_axis_tdata[lsm_pkg::WORD_W-1:0] == want_addr_reg);
    assign hold_ok = m_axis_tvalid && (beat_next == beat_reg);

    // The block never takes a new instruction while results are outstanding.
    `LSM_ASSERT_NOW(a_no_overlap, clk, rst_n, m_axis_tvalid, !s_axis_tready, "ready while busy")

    // An accepted instruction keeps the input closed in the following cycle.
    `LSM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_take, !s_axis_tready, "ready after accept")

    // An illegal result is alone and transfers nothing.
    `LSM_ASSERT_NOW(a_illegal_single, clk, rst_n, ill_shown, lone_end, "illegal result not alone")

    // Successive transfers of one instruction follow at once, four bytes apart.
    `LSM_ASSERT_NEXT(a_addr_step, clk, rst_n, step_take, step_ok, "address step not four")

    // A stalled result holds.
    `LSM_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_stall, hold_ok, "stalled result changed")

endmodule

bind load_store_multiple_sequencer lsm_checker u_lsm_checker (.*);
